// ===== sv/chunked_body_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Chunked body decoder assertion macros
// Clocked, reset-gated assertion forms used by the RTL decoder.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_BODY_DECODER_ASSERT_SVH
`define CHUNKED_BODY_DECODER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define CBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define CBD_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define CBD_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Phase codes, character constants and byte classification functions.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    typedef enum logic [1:0] {
        PH_SIZE  = 2'd0,
        PH_DATA  = 2'd1,
        PH_CLOSE = 2'd2,
        PH_EXT   = 2'd3
    } phase_t;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    localparam logic [2:0] EXT_IDLE = 3'd0;
    localparam logic [2:0] EXT_FULL = 3'd4;
    localparam logic [2:0] EXT_TAIL = 3'd5;
    localparam logic [2:0] EXT_DEAD = 3'd6;

    localparam logic [7:0] EXT_WORD [4] = '{8'h69, 8'h65, 8'h6F, 8'h66};

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_val(input logic [7:0] b);
        hex_t r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r.val = 4'(b - 8'h30);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r.val = 4'(b - 8'h37);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r.val = 4'(b - 8'h57);
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A ||
               b == 8'h0B || b == 8'h0C;
    endfunction

    function automatic logic [2:0] ext_step(input logic [2:0] m, input logic [7:0] b);
        logic [2:0] r;
        if (is_ws(b))
        begin
            if (m == EXT_FULL || m == EXT_TAIL)
            begin
                r = EXT_TAIL;
            end
            else if (m != EXT_IDLE)
            begin
                r = EXT_DEAD;
            end
            else
            begin
                r = m;
            end
        end
        else if (m < EXT_FULL && b == EXT_WORD[m[1:0]])
        begin
            r = m + 3'd1;
        end
        else
        begin
            r = EXT_DEAD;
        end
        return r;
    endfunction

endpackage

// ===== sv/chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder
// Parses hex size lines, passes chunk payload and checks the closing CRLF.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the raw chunked body, one byte per transfer in tdata.
//   m_axis returns exactly one result per input byte: tdata is the payload
//   byte (zero when not payload), tlast marks the LF that completes a chunk,
//   and tuser flags payload, a zero-size chunk, the "ieof" extension and
//   framing errors (size overflow or stray bytes before the closing CRLF).
//   The result is registered and shows in the cycle after the input transfer;
//   throughput is one byte per cycle while the receiver keeps up, set by the
//   single result register, freed in the same cycle its contents are taken.
//   When the receiver stalls, the result register holds and s_axis_tready
//   drops until the held result is taken; no byte is lost or dropped.
//   Reset empties the result register and returns the parser to the start
//   of a size line with a zero size and a cleared extension matcher.
// ----------------------------------------------------------------------------
module chunked_body_decoder #(
    parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // chunk_done
    output logic [3:0] m_axis_tuser    // [0] payload_valid [1] final_chunk
                                       // [2] ieof_mark [3] frame_error
);

    import cbd_pkg::*;

    `include "chunked_body_decoder_assert.svh"

    phase_t               phase_reg, phase_next;
    logic                 prev_cr_reg, prev_cr_next;
    logic [SIZE_BITS-1:0] chunk_length_reg, chunk_length_next;
    logic [SIZE_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [2:0]           ext_match_reg, ext_match_next;
    logic                 size_overflow_reg, size_overflow_next;

    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_done_reg, out_done_next;
    logic [3:0]           out_user_reg, out_user_next;

    logic                 s_fire;
    logic [7:0]           b;
    logic                 line_end;
    logic                 is_cr;
    logic                 len_zero;
    logic                 left_last;
    logic                 digit_ovf;
    hex_t                 hex;
    logic [2:0]           ext_pend;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    assign is_cr     = (b == CH_CR);
    assign line_end  = (b == CH_LF) && prev_cr_reg;
    assign len_zero  = (chunk_length_reg == '0);
    assign left_last = (bytes_left_reg[SIZE_BITS-1:1] == '0);
    assign digit_ovf = (chunk_length_reg[SIZE_BITS-1 -: 4] != 4'd0);
    assign hex       = hex_val(b);
    assign ext_pend  = prev_cr_reg ? ext_step(ext_match_reg, CH_CR) : ext_match_reg;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SIZE:
            begin
                if (line_end)
                begin
                    phase_next = len_zero ? PH_CLOSE : PH_DATA;
                end
                else if (b == CH_SEMI)
                begin
                    phase_next = PH_EXT;
                end
            end
            PH_EXT:
            begin
                if (line_end)
                begin
                    phase_next = len_zero ? PH_CLOSE : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (left_last)
                begin
                    phase_next = PH_CLOSE;
                end
            end
            PH_CLOSE:
            begin
                if (line_end)
                begin
                    phase_next = PH_SIZE;
                end
            end
            default:
            begin
                phase_next = PH_SIZE;
            end
        endcase
    end

    always_comb
    begin
        prev_cr_next       = prev_cr_reg;
        chunk_length_next  = chunk_length_reg;
        bytes_left_next    = bytes_left_reg;
        ext_match_next     = ext_match_reg;
        size_overflow_next = size_overflow_reg;
        out_byte_next      = 8'd0;
        out_done_next      = 1'b0;
        out_user_next      = 4'd0;
        unique case (phase_reg)
            PH_SIZE:
            begin
                if (line_end)
                begin
                    bytes_left_next = chunk_length_reg;
                    prev_cr_next    = 1'b0;
                end
                else
                begin
                    prev_cr_next = is_cr;
                    if (b != CH_SEMI && hex.ok)
                    begin
                        if (digit_ovf)
                        begin
                            out_user_next[3]   = !size_overflow_reg;
                            size_overflow_next = 1'b1;
                            chunk_length_next  = '1;
                        end
                        else
                        begin
                            chunk_length_next = {chunk_length_reg[SIZE_BITS-5:0], hex.val};
                        end
                    end
                end
            end
            PH_EXT:
            begin
                if (line_end)
                begin
                    bytes_left_next = chunk_length_reg;
                    prev_cr_next    = 1'b0;
                end
                else if (is_cr)
                begin
                    prev_cr_next   = 1'b1;
                    ext_match_next = ext_pend;
                end
                else
                begin
                    prev_cr_next   = 1'b0;
                    ext_match_next = ext_step(ext_pend, b);
                end
            end
            PH_DATA:
            begin
                out_byte_next    = b;
                out_user_next[0] = 1'b1;
                bytes_left_next  = bytes_left_reg - SIZE_BITS'(bytes_left_reg != '0);
                if (left_last)
                begin
                    prev_cr_next = 1'b0;
                end
            end
            PH_CLOSE:
            begin
                if (line_end)
                begin
                    out_done_next      = 1'b1;
                    out_user_next[1]   = len_zero;
                    out_user_next[2]   = (ext_match_reg == EXT_FULL) ||
                                         (ext_match_reg == EXT_TAIL);
                    prev_cr_next       = 1'b0;
                    chunk_length_next  = '0;
                    bytes_left_next    = '0;
                    ext_match_next     = EXT_IDLE;
                    size_overflow_next = 1'b0;
                end
                else if (is_cr)
                begin
                    out_user_next[3] = prev_cr_reg;
                    prev_cr_next     = 1'b1;
                end
                else
                begin
                    out_user_next[3] = 1'b1;
                    prev_cr_next     = 1'b0;
                end
            end
            default:
            begin
                prev_cr_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SIZE;
            prev_cr_reg       <= 1'b0;
            chunk_length_reg  <= '0;
            bytes_left_reg    <= '0;
            ext_match_reg     <= EXT_IDLE;
            size_overflow_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                phase_reg         <= phase_next;
                prev_cr_reg       <= prev_cr_next;
                chunk_length_reg  <= chunk_length_next;
                bytes_left_reg    <= bytes_left_next;
                ext_match_reg     <= ext_match_next;
                size_overflow_reg <= size_overflow_next;
            end
            if (s_axis_tready)
            begin
                out_valid_reg <= s_axis_tvalid;
            end
        end
    end

    // Load the result register on every input transfer.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            out_byte_reg <= out_byte_next;
            out_done_reg <= out_done_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_done_reg;
    assign m_axis_tuser  = out_user_reg;

    `CBD_ASSERT_IMPL(a_data_has_count, phase_reg == PH_DATA, bytes_left_reg != '0,
        "data phase with no bytes left")
    `CBD_ASSERT_IMPL(a_payload_not_done, out_valid_reg && out_user_reg[0],
        !out_done_reg && !out_user_reg[1] && !out_user_reg[2],
        "payload result carries chunk completion flags")
    `CBD_ASSERT_IMPL(a_final_needs_done, out_valid_reg && (out_user_reg[1] || out_user_reg[2]),
        out_done_reg, "final or ieof flag without chunk completion")
    `CBD_ASSERT_NEXT(a_close_restarts, s_fire && phase_reg == PH_CLOSE && line_end,
        phase_reg == PH_SIZE && chunk_length_reg == '0 && ext_match_reg == EXT_IDLE,
        "closing CRLF did not restart the size line")

endmodule

// ===== verif/cbd_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chunked body decoder stream checker
// Watches both stream channels. Each input byte is decoded by a local copy
// of the size/extension/data/close parser. The expected result is queued.
// Each result transfer is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module cbd_stream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic       m_axis_tlast,
    input  logic [3:0] m_axis_tuser,
    output int         fail_count,
    output int         pending,
    output int         n_bytes,
    output int         n_payload,
    output int         n_chunks,
    output int         n_zero_size,
    output int         n_ieof,
    output int         n_errors
);

    import cbd_pkg::*;

    localparam int SZ = SIZE_BITS_DEF;
    localparam logic [SZ-1:0] SIZE_LIMIT = '1;

    typedef struct packed {
        logic [7:0] data;
        logic       payload;
        logic       done;
        logic       zero_size;
        logic       ieof;
        logic       err;
    } chunk_result_t;

    chunk_result_t expected_q[$];

    phase_t        parse_phase;
    logic          cr_pending;
    logic [SZ-1:0] size_acc;
    logic [SZ-1:0] payload_left;
    logic [2:0]    ext_state;
    logic          size_sat;
    int            n_checked;

    task automatic restart_line();
        parse_phase  = PH_SIZE;
        cr_pending   = 1'b0;
        size_acc     = '0;
        payload_left = '0;
        ext_state    = EXT_IDLE;
        size_sat     = 1'b0;
    endtask

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
        begin
            return int'(b) - 'h30;
        end
        if (b >= 8'h41 && b <= 8'h46)
        begin
            return int'(b) - 'h41 + 10;
        end
        if (b >= 8'h61 && b <= 8'h66)
        begin
            return int'(b) - 'h61 + 10;
        end
        return -1;
    endfunction

    function automatic logic [2:0] ext_next(input logic [2:0] m, input logic [7:0] b);
        logic blank;
        blank = (b == 8'h20) || (b == 8'h09) || (b == CH_CR) || (b == CH_LF) ||
                (b == 8'h0B) || (b == 8'h0C);
        if (blank)
        begin
            if (m == EXT_FULL || m == EXT_TAIL)
            begin
                return EXT_TAIL;
            end
            return (m == EXT_IDLE) ? EXT_IDLE : EXT_DEAD;
        end
        if (m < EXT_FULL && b == EXT_WORD[m[1:0]])
        begin
            return m + 3'd1;
        end
        return EXT_DEAD;
    endfunction

    task automatic decode_byte(input logic [7:0] b, output chunk_result_t r);
        int d;
        r = '0;
        case (parse_phase)
            PH_DATA:
            begin
                r.data    = b;
                r.payload = 1'b1;
                if (payload_left != 0)
                begin
                    payload_left = payload_left - 1'b1;
                end
                if (payload_left == 0)
                begin
                    parse_phase = PH_CLOSE;
                    cr_pending  = 1'b0;
                end
            end
            PH_CLOSE:
            begin
                if (b == CH_LF && cr_pending)
                begin
                    r.done      = 1'b1;
                    r.zero_size = (size_acc == 0);
                    r.ieof      = (ext_state == EXT_FULL || ext_state == EXT_TAIL);
                    restart_line();
                end
                else if (b == CH_CR)
                begin
                    r.err      = cr_pending;
                    cr_pending = 1'b1;
                end
                else
                begin
                    r.err      = 1'b1;
                    cr_pending = 1'b0;
                end
            end
            default:
            begin
                if (b == CH_LF && cr_pending)
                begin
                    payload_left = size_acc;
                    cr_pending   = 1'b0;
                    if (size_acc == 0)
                    begin
                        parse_phase = PH_CLOSE;
                    end
                    else
                    begin
                        parse_phase = PH_DATA;
                    end
                end
                else if (parse_phase == PH_EXT)
                begin
                    // a held CR turned out not to start CRLF: feed it as text
                    if (cr_pending)
                    begin
                        ext_state = ext_next(ext_state, CH_CR);
                    end
                    cr_pending = (b == CH_CR);
                    if (b != CH_CR)
                    begin
                        ext_state = ext_next(ext_state, b);
                    end
                end
                else
                begin
                    cr_pending = (b == CH_CR);
                    d = hex_digit(b);
                    if (b == CH_SEMI)
                    begin
                        parse_phase = PH_EXT;
                    end
                    else if (d >= 0)
                    begin
                        if (size_acc > ((SIZE_LIMIT - SZ'(d)) >> 4))
                        begin
                            r.err    = !size_sat;
                            size_sat = 1'b1;
                            size_acc = SIZE_LIMIT;
                        end
                        else
                        begin
                            size_acc = (size_acc << 4) + SZ'(d);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
                 n_checked, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report(what, got, want);
        end
    endtask

    always @(posedge clk)
    begin
        chunk_result_t want;
        chunk_result_t r;
        if (!rst_n)
        begin
            restart_line();
            expected_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    report("result with nothing expected, tdata", m_axis_tdata, 8'h00);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("out_byte", m_axis_tdata, want.data);
                    check_field("payload_valid", 8'(m_axis_tuser[0]), 8'(want.payload));
                    check_field("chunk_done", 8'(m_axis_tlast), 8'(want.done));
                    check_field("final_chunk", 8'(m_axis_tuser[1]), 8'(want.zero_size));
                    check_field("ieof_mark", 8'(m_axis_tuser[2]), 8'(want.ieof));
                    check_field("frame_error", 8'(m_axis_tuser[3]), 8'(want.err));
                end
                n_checked++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(s_axis_tdata, r);
                expected_q.push_back(r);
                n_bytes++;
                n_payload   += r.payload;
                n_chunks    += r.done;
                n_zero_size += r.zero_size;
                n_ieof      += r.ieof;
                n_errors    += r.err;
            end
        end
        pending <= expected_q.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chunked body decoder testbench
// Feeds directed chunked bodies (empty and zero sizes, extensions with and
// without the ieof marker, stray closing bytes), then random chunk streams,
// and ends with a size overflow. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    import cbd_pkg::*;

    localparam int ITEMS          = 750;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [3:0] m_axis_tuser;

    logic calm = 1'b0;
    int   quiet;
    int   stall_left;
    int   sent;
    int   fail_count, pending;
    int   n_bytes, n_payload, n_chunks, n_zero_size, n_ieof, n_errors;

    chunked_body_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    cbd_stream_checker stream_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .n_bytes       (n_bytes),
        .n_payload     (n_payload),
        .n_chunks      (n_chunks),
        .n_zero_size   (n_zero_size),
        .n_ieof        (n_ieof),
        .n_errors      (n_errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                stall_left = $urandom_range(15, 40);
            end
            else
            begin
                stall_left = $urandom_range(0, 2);
            end
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    initial
    begin
        wait (quiet >= WATCHDOG_LIMIT);
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int r;
        int gap;
        gap = 0;
        if (!calm)
        begin
            r = $urandom_range(0, 99);
            if (r >= 98)
            begin
                gap = $urandom_range(20, 40);
            end
            else if (r >= 90)
            begin
                gap = $urandom_range(4, 10);
            end
            else if (r >= 60)
            begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    // hold off the sender until every queued result has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] other_byte(input logic [7:0] avoid);
        logic [7:0] r;
        do r = 8'($urandom_range(0, 255)); while (r == avoid);
        return r;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0B;
            3:       return 8'h0C;
            default: return CH_LF;
        endcase
    endfunction

    initial
    begin
        int         len;
        int         r;
        int         nib;
        int         chunk_no;
        bit         started;
        logic [7:0] b;
        hex_t       h;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty size part, then a zero-size chunk carrying ieof
        send_text("\r\n\r\n");
        send_text("0;ieof\r\n\r\n");
        // ignored junk, lone LF and lone CR in the size part; payload extreme
        send_text("g\n\r1\r\n");
        send_byte(8'hFF);
        send_text("\r\n");
        // padded extension with a trailing bare LF; CR as payload; stray closing bytes
        send_text("2;\t ieof\n\r\n");
        send_byte(8'h00);
        send_byte(CH_CR);
        send_text("\nx\r\r\n");
        // CR inside the extension not followed by LF, mixed-case hex
        send_text("0;ieof\r \r\n\r\n");
        send_text("aB;IEOF\r\n");
        repeat (171) send_byte(8'($urandom_range(0, 255)));
        send_text("\r\n");
        drain();

        chunk_no = 0;
        while (sent < ITEMS)
        begin
            calm <= ($urandom_range(0, 5) == 0);
            if (chunk_no == 15)
            begin
                drain();
            end
            chunk_no++;

            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                len = 0;
            end
            else if (r < 85)
            begin
                len = $urandom_range(1, 8);
            end
            else
            begin
                len = $urandom_range(9, 48);
            end

            if ($urandom_range(0, 7) == 0)
            begin
                do
                begin
                    b = 8'($urandom_range(0, 255));
                    h = hex_val(b);
                end
                while (h.ok || b == CH_SEMI || b == CH_CR);
                send_byte(b);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 2)) send_byte("0");
            end
            started = 1'b0;
            for (int sh = 28; sh >= 0; sh -= 4)
            begin
                nib = (len >> sh) & 15;
                if (nib != 0 || started)
                begin
                    started = 1'b1;
                    if (nib < 10)
                    begin
                        b = 8'(8'h30 + nib);
                    end
                    else if ($urandom_range(0, 1) == 1)
                    begin
                        b = 8'(8'h41 + nib - 10);
                    end
                    else
                    begin
                        b = 8'(8'h61 + nib - 10);
                    end
                    send_byte(b);
                end
            end

            case ($urandom_range(0, 5))
                0: ;
                1: send_text(";ieof");
                2:
                begin
                    send_byte(CH_SEMI);
                    repeat ($urandom_range(0, 2)) send_byte(pick_blank());
                    send_text("ieof");
                    repeat ($urandom_range(0, 2)) send_byte(pick_blank());
                end
                3:
                begin
                    case ($urandom_range(0, 3))
                        0:       send_text(";ie");
                        1:       send_text(";ieofx");
                        2:       send_text(";i eof");
                        default: send_text("; ieof ieof");
                    endcase
                end
                4:
                begin
                    send_byte(CH_SEMI);
                    repeat ($urandom_range(1, 6)) send_byte(other_byte(CH_CR));
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        send_text(";ieof\r\t");
                    end
                    else
                    begin
                        send_text(";\nieof");
                    end
                end
            endcase
            send_text("\r\n");

            repeat (len) send_byte(8'($urandom_range(0, 255)));

            case ($urandom_range(0, 7))
                0:
                begin
                    repeat ($urandom_range(1, 3)) send_byte(other_byte(CH_CR));
                    send_text("\r\n");
                end
                1:       send_text("\r\r\n");
                default: send_text("\r\n");
            endcase
        end

        // saturate the size; the stream stays in payload from here on
        calm <= 1'b0;
        send_text("fFfFfFfF01;x\r\n");
        repeat (40) send_byte(8'($urandom_range(0, 255)));

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes: %0d payload, %0d chunks closed (%0d zero-size, %0d ieof)",
                 n_bytes, n_payload, n_chunks, n_zero_size, n_ieof);
        $display("Framing errors flagged: %0d (size overflow and stray closing bytes)",
                 n_errors);
        if (fail_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/cbd_pkg.sv
sv/chunked_body_decoder.sv
verif/cbd_stream_checker.sv
verif/tb.sv
